>>> rtl/acs5_pkg.sv
// ----------------------------------------------------------------------------
// acs5_pkg
// shared types and constants for the _S5_ package scanner
// ----------------------------------------------------------------------------
package acs5_pkg;

  // aml opcodes and prefixes
  localparam logic [7:0] OpName     = 8'h08;
  localparam logic [7:0] OpPackage  = 8'h12;
  localparam logic [7:0] BytePrefix = 8'h0A;
  localparam logic [7:0] RootPrefix = 8'h5C;
  localparam logic [7:0] LeadMask   = 8'hC0;

  // name characters
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] Ch5     = 8'h35;

  // history window, oldest byte at index 0
  localparam int unsigned WinDepth = 6;
  typedef logic [WinDepth-1:0][7:0] window_t;

  // saturating byte counter, holds 0 .. WinDepth
  typedef logic [2:0] seen_t;

endpackage

>>> rtl/acpi_s5_package_scanner.sv
// ----------------------------------------------------------------------------
// acpi_s5_package_scanner
// scans a dsdt body byte stream for the _S5_ package and its sleep types
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o  | table_byte_i, end_of_table_i
//  out     | output    | out_valid_o/out_ready_i| found_o, sleep_type_a_o/_b_o
//
//  one byte is taken per cycle; all scan state updates at the accepting edge
//  a request marked end_of_table yields one result in the result register on
//  the following cycle, and all scan state returns to its reset values
//  the input stalls only while a result is held and out_ready_i is low
//  reset (rst_ni low, asynchronous) clears the window, phase and result valid
//
module acpi_s5_package_scanner import acs5_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] table_byte_i,
  input  logic       end_of_table_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       found_o,
  output logic [7:0] sleep_type_a_o,
  output logic [7:0] sleep_type_b_o
);

  // scan phases
  localparam logic [2:0] PhSearch = 3'd0;
  localparam logic [2:0] PhLead   = 3'd1;
  localparam logic [2:0] PhSkip   = 3'd2;
  localparam logic [2:0] PhAFirst = 3'd3;
  localparam logic [2:0] PhAValue = 3'd4;
  localparam logic [2:0] PhBFirst = 3'd5;
  localparam logic [2:0] PhBValue = 3'd6;
  localparam logic [2:0] PhDone   = 3'd7;

  window_t    window_q, window_d;
  seen_t      seen_q, seen_d;
  logic [2:0] phase_q, phase_d;
  logic [2:0] skip_q, skip_d;
  logic [7:0] type_a_q, type_a_d;
  logic [7:0] type_b_q, type_b_d;
  logic       done_q, done_d;

  logic       out_valid_q;
  logic       found_q;
  logic [7:0] res_a_q, res_b_q;

  logic       in_fire;
  logic       name_hit;

  // a held result that is being taken frees the register in the same cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  acs5_name_match u_match (
    .window_i     (window_q),
    .bytes_seen_i (seen_q),
    .cur_byte_i   (table_byte_i),
    .hit_o        (name_hit)
  );

  // phase sequencer, one step per request
  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    type_a_d = type_a_q;
    type_b_d = type_b_q;
    done_d   = done_q;
    case (phase_q)
      PhSearch: begin
        if (name_hit) phase_d = PhLead;
      end
      PhLead: begin
        // lead bits give the count of extra length bytes; plus the element count
        skip_d  = 3'({1'b0, table_byte_i[7:6]}) + 3'd1;
        phase_d = PhSkip;
      end
      PhSkip: begin
        skip_d = skip_q - 3'd1;
        if (skip_q == 3'd1) phase_d = PhAFirst;
      end
      PhAFirst: begin
        if (table_byte_i == BytePrefix) begin
          phase_d = PhAValue;
        end else begin
          type_a_d = table_byte_i;
          phase_d  = PhBFirst;
        end
      end
      PhAValue: begin
        type_a_d = table_byte_i;
        phase_d  = PhBFirst;
      end
      PhBFirst: begin
        if (table_byte_i == BytePrefix) begin
          phase_d = PhBValue;
        end else begin
          type_b_d = table_byte_i;
          done_d   = 1'b1;
          phase_d  = PhDone;
        end
      end
      PhBValue: begin
        type_b_d = table_byte_i;
        done_d   = 1'b1;
        phase_d  = PhDone;
      end
      default: begin
        // first match stays, later bytes are ignored
      end
    endcase
  end

  // history shift and saturating byte count
  assign window_d = {table_byte_i, window_q[WinDepth-1:1]};
  assign seen_d   = (seen_q < seen_t'(WinDepth)) ? seen_q + seen_t'(1) : seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      seen_q   <= '0;
      phase_q  <= PhSearch;
      skip_q   <= '0;
      type_a_q <= '0;
      type_b_q <= '0;
      done_q   <= 1'b0;
    end else if (in_fire) begin
      if (end_of_table_i) begin
        // table closed, start over for the next one
        window_q <= '0;
        seen_q   <= '0;
        phase_q  <= PhSearch;
        skip_q   <= '0;
        type_a_q <= '0;
        type_b_q <= '0;
        done_q   <= 1'b0;
      end else begin
        window_q <= window_d;
        seen_q   <= seen_d;
        phase_q  <= phase_d;
        skip_q   <= skip_d;
        type_a_q <= type_a_d;
        type_b_q <= type_b_d;
        done_q   <= done_d;
      end
    end
  end

  // result register, the last byte may itself complete the capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && end_of_table_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && end_of_table_i) begin
      found_q <= done_d;
      res_a_q <= done_d ? type_a_d : 8'h00;
      res_b_q <= done_d ? type_b_d : 8'h00;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign sleep_type_a_o = res_a_q;
  assign sleep_type_b_o = res_b_q;

  // checks

  // a finished capture and the done phase always go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q == (phase_q == PhDone))
    else $error("match flag and phase disagree");

  // a closing request always produces a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_table_i |=> out_valid_o)
    else $error("no result after last byte");

  // a not-found result carries zero sleep types
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> sleep_type_a_o == 8'h00 && sleep_type_b_o == 8'h00)
    else $error("sleep types nonzero without match");

  // scan state is back at its start after the last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_table_i |=> phase_q == PhSearch && seen_q == seen_t'(0))
    else $error("scan state not cleared at table end");

endmodule

>>> rtl/acs5_name_match.sv
// ----------------------------------------------------------------------------
// acs5_name_match
// detects NameOp [root] "_S5_" PackageOp ending at the current byte
// ----------------------------------------------------------------------------
module acs5_name_match import acs5_pkg::*; (
  input  window_t    window_i,
  input  seen_t      bytes_seen_i,
  input  logic [7:0] cur_byte_i,
  output logic       hit_o
);

  logic name_ok;
  logic direct;
  logic rooted;

  assign name_ok = (window_i[2] == ChUnder) && (window_i[3] == ChS) &&
                   (window_i[4] == Ch5) && (window_i[5] == ChUnder);

  // the opcode bytes must really have arrived in this table
  assign direct = (bytes_seen_i >= seen_t'(5)) && (window_i[1] == OpName);
  assign rooted = (bytes_seen_i >= seen_t'(6)) && (window_i[0] == OpName) &&
                  (window_i[1] == RootPrefix);

  assign hit_o = (cur_byte_i == OpPackage) && name_ok && (direct || rooted);

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the _S5_ package scanner: dsdt body bytes are sent
// as requests, a scoreboard predicts each end-of-table report and compares it
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acs5_pkg::*;

  // generous ceiling for the watchdog
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned BodyBudget = 1400;

  // scan phases as the scanner walks through one _S5_ package
  typedef enum logic [2:0] {
    ScanSearch,
    ScanLead,
    ScanSkip,
    ScanAFirst,
    ScanAValue,
    ScanBFirst,
    ScanBValue,
    ScanDone
  } scan_phase_e;

  typedef struct packed {
    logic       found;
    logic [7:0] type_a;
    logic [7:0] type_b;
  } sleep_report_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the scan state and keeps the reports still owed
  // --------------------------------------------------------------------------
  class sleep_type_scoreboard;
    window_t       win;
    seen_t         seen;
    scan_phase_e   phase;
    logic [2:0]    skip_left;
    logic [7:0]    held_a;
    logic [7:0]    held_b;
    logic          matched;
    sleep_report_t reports_due[$];
    int unsigned   mismatches;
    int unsigned   reports_checked;
    int unsigned   reports_found;

    function new();
      clear_scan();
      mismatches      = 0;
      reports_checked = 0;
      reports_found   = 0;
    endfunction

    function void clear_scan();
      win       = '0;
      seen      = '0;
      phase     = ScanSearch;
      skip_left = '0;
      held_a    = '0;
      held_b    = '0;
      matched   = 1'b0;
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction

    // the current byte is a package op closing "_S5_" after a name op,
    // directly or behind a root prefix, all received in this table
    function bit name_before_package(logic [7:0] value);
      bit direct;
      bit rooted;
      if (value != OpPackage) return 1'b0;
      if (win[2] != ChUnder || win[3] != ChS || win[4] != Ch5 || win[5] != ChUnder)
        return 1'b0;
      direct = (seen >= 3'd5) && (win[1] == OpName);
      rooted = (seen >= 3'd6) && (win[0] == OpName) && (win[1] == RootPrefix);
      return direct || rooted;
    endfunction

    function void note_request(logic [7:0] value, logic last);
      sleep_report_t rep;
      int            i;
      case (phase)
        ScanSearch: begin
          if (name_before_package(value)) phase = ScanLead;
        end
        ScanLead: begin
          skip_left = {1'b0, value[7:6]} + 3'd1;
          phase     = ScanSkip;
        end
        ScanSkip: begin
          skip_left = skip_left - 3'd1;
          if (skip_left == 3'd0) phase = ScanAFirst;
        end
        ScanAFirst: begin
          if (value == BytePrefix) begin
            phase = ScanAValue;
          end else begin
            held_a = value;
            phase  = ScanBFirst;
          end
        end
        ScanAValue: begin
          held_a = value;
          phase  = ScanBFirst;
        end
        ScanBFirst: begin
          if (value == BytePrefix) begin
            phase = ScanBValue;
          end else begin
            held_b  = value;
            matched = 1'b1;
            phase   = ScanDone;
          end
        end
        ScanBValue: begin
          held_b  = value;
          matched = 1'b1;
          phase   = ScanDone;
        end
        default: begin
        end
      endcase
      for (i = 0; i < WinDepth - 1; i++) win[i] = win[i+1];
      win[WinDepth-1] = value;
      if (seen < 3'(WinDepth)) seen = seen + 3'd1;
      if (last) begin
        rep.found  = matched;
        rep.type_a = matched ? held_a : 8'h00;
        rep.type_b = matched ? held_b : 8'h00;
        reports_due.push_back(rep);
        clear_scan();
      end
    endfunction

    function void check_result(logic found, logic [7:0] type_a, logic [7:0] type_b);
      sleep_report_t want;
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected report found=%0d a=0x%02h b=0x%02h",
                 $time, found, type_a, type_b);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      reports_checked++;
      if (want.found) reports_found++;
      if (found !== want.found) begin
        $display("%0t: found mismatch, expected %0d actual %0d", $time, want.found, found);
        mismatches++;
      end
      if (type_a !== want.type_a) begin
        $display("%0t: sleep_type_a mismatch, expected 0x%02h actual 0x%02h",
                 $time, want.type_a, type_a);
        mismatches++;
      end
      if (type_b !== want.type_b) begin
        $display("%0t: sleep_type_b mismatch, expected 0x%02h actual 0x%02h",
                 $time, want.type_b, type_b);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports; the driven inputs are known from time zero
  // --------------------------------------------------------------------------
  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] table_byte_i   = 8'h00;
  logic       end_of_table_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic       found_o;
  logic [7:0] sleep_type_a_o;
  logic [7:0] sleep_type_b_o;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  acpi_s5_package_scanner u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .table_byte_i   (table_byte_i),
    .end_of_table_i (end_of_table_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .sleep_type_a_o (sleep_type_a_o),
    .sleep_type_b_o (sleep_type_b_o)
  );

  sleep_type_scoreboard sb;
  logic [7:0]           body_q[$];     // bytes of the table body being built
  bit                   pace_tight;    // no idling on either side while set
  int unsigned          bytes_sent  = 0;
  int unsigned          bodies_sent = 0;
  int unsigned          cycle_count = 0;

  // watchdog, a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL acpi_s5_package_scanner");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stalls before each report, sampled at the taking edge
  // --------------------------------------------------------------------------
  initial begin : report_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pace_tight ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      // ready stays high straight into the next report when no stall is drawn
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_ready_i));
      sb.check_result(found_o, sleep_type_a_o, sleep_type_b_o);
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // one byte request; valid only drops when a gap is drawn
  task automatic push_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    gap = pace_tight ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    table_byte_i   <= value;
    end_of_table_i <= last;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o === 1'b1));
    sb.note_request(value, last);
    bytes_sent++;
  endtask

  // whole body, the final byte carries end_of_table
  task automatic send_body();
    int i;
    for (i = 0; i < body_q.size(); i++) push_byte(body_q[i], i == body_q.size() - 1);
    bodies_sent++;
  endtask

  // hold requests back until every owed report has come out
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // filler biased toward the bytes the scanner cares about, for near misses
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0:       return OpName;
      1:       return RootPrefix;
      2:       return ChUnder;
      3:       return ChS;
      4:       return Ch5;
      5:       return OpPackage;
      6:       return BytePrefix;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // sleep value, half of them behind a byte prefix
  task automatic append_value();
    if ($urandom_range(0, 1) == 1) begin
      body_q.push_back(BytePrefix);
      body_q.push_back(($urandom_range(0, 3) == 0) ? BytePrefix : 8'($urandom_range(0, 255)));
    end else begin
      body_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // name op, optional root prefix, "_S5_", package op, length, count, values;
  // a broken header gets one bit flipped somewhere in it
  task automatic append_package(input bit broken);
    int unsigned start;
    int unsigned idx;
    int unsigned skip_bytes;
    logic [7:0]  lead;
    start = body_q.size();
    body_q.push_back(OpName);
    if ($urandom_range(0, 1) == 1) body_q.push_back(RootPrefix);
    body_q.push_back(ChUnder);
    body_q.push_back(ChS);
    body_q.push_back(Ch5);
    body_q.push_back(ChUnder);
    body_q.push_back(OpPackage);
    if (broken) begin
      idx = $urandom_range(start, body_q.size() - 1);
      body_q[idx] = body_q[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    // lead byte top bits give the number of extra length bytes
    lead = 8'($urandom_range(0, 255));
    body_q.push_back(lead);
    skip_bytes = lead[7:6] + 1;
    repeat (skip_bytes) body_q.push_back(noise_byte());
    append_value();
    append_value();
  endtask

  // mostly well-formed packages with random content, some noise-only bodies,
  // some broken headers, some second packages and some cut-short bodies
  task automatic build_random_body();
    int unsigned kind;
    int unsigned keep;
    body_q.delete();
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 6)) body_q.push_back(noise_byte());
    if (kind < 10) begin
      repeat ($urandom_range(1, 24)) body_q.push_back(noise_byte());
    end else begin
      append_package(kind < 22);
      if ($urandom_range(0, 3) == 0) append_package($urandom_range(0, 1) == 1);
      repeat ($urandom_range(0, 4)) body_q.push_back(noise_byte());
      if ($urandom_range(0, 4) == 0) begin
        keep = $urandom_range(1, body_q.size());
        while (body_q.size() > keep) void'(body_q.pop_back());
      end
    end
    if (body_q.size() == 0) body_q.push_back(noise_byte());
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    pace_tight = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // table ends partway through a rooted name: nothing found
    body_q = '{OpName, RootPrefix, ChUnder, ChS, Ch5};
    send_body();
    // "_" then package op would complete a rooted match only if the window
    // leaked across the table boundary
    body_q = '{ChUnder, OpPackage, 8'hFF};
    send_body();
    // package op as first byte after a boundary, then a direct match with
    // byte prefixes on both values, extreme values, and a byte after the match
    body_q = '{OpPackage, OpName, ChUnder, ChS, Ch5, ChUnder, OpPackage, 8'h00, 8'h3C,
               BytePrefix, 8'h00, BytePrefix, 8'hFF, OpPackage};
    send_body();
    // rooted match, longest length field, sleep_type_b on the final byte
    pace_tight = 1'b1;
    body_q = '{OpName, RootPrefix, ChUnder, ChS, Ch5, ChUnder, OpPackage, 8'hC0,
               8'h01, 8'h02, 8'h03, 8'h04, 8'h7F, 8'h80};
    send_body();
    drain_reports();

    while (bytes_sent < BodyBudget) begin
      // roughly one body in five runs with no idling at all
      pace_tight = ($urandom_range(0, 4) == 0);
      build_random_body();
      send_body();
      if ($urandom_range(0, 11) == 0) drain_reports();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // wait on so that a stray report would show up
    repeat (8) @(posedge clk_i);

    $display("covered %0d table bodies in %0d byte requests, %0d reports checked",
             bodies_sent, bytes_sent, sb.reports_checked);
    $display("%0d reports carried a captured _S5_ package, %0d mismatches",
             sb.reports_found, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS acpi_s5_package_scanner");
    end else begin
      $display("FAIL acpi_s5_package_scanner");
    end
    $finish;
  end

endmodule
